### src/prmq_pkg.sv
// package: shared constants, types and the log table for the mapping quality block
package prmq_pkg;

	localparam int LOG_TABLE_DEPTH = 256;
	localparam int LOG_IDX_W = $clog2(LOG_TABLE_DEPTH);
	localparam int LOG_VAL_W = 5;
	localparam int LOG_STEP_COUNT = 30;
	localparam int COUNT_W = 16;
	localparam int QUAL_W = 6;

	// smallest index whose rounded 4.343*ln(i) reaches k+1
	localparam logic [9:0] LOG_STEPS [LOG_STEP_COUNT] = '{
		10'd2, 10'd2, 10'd2, 10'd3, 10'd3, 10'd4, 10'd5, 10'd6, 10'd8, 10'd9,
		10'd12, 10'd15, 10'd18, 10'd23, 10'd29, 10'd36, 10'd45, 10'd57, 10'd71, 10'd90,
		10'd113, 10'd142, 10'd178, 10'd224, 10'd282, 10'd355, 10'd447, 10'd563, 10'd708,
		10'd892
	};

	localparam logic [QUAL_W-1:0] Q_UNIQUE      = 6'd37;
	localparam logic [QUAL_W-1:0] Q_BASE        = 6'd23;
	localparam logic [QUAL_W-1:0] Q_MAX         = 6'd60;
	localparam logic [QUAL_W-1:0] Q_PAIR_UNIQUE = 6'd29;
	localparam logic [QUAL_W-1:0] Q_PAIR_CLEAR  = 6'd23;
	localparam logic [QUAL_W-1:0] Q_PAIR_BONUS  = 6'd7;
	localparam logic [QUAL_W-1:0] Q_PAIR_SAT    = 6'd63;

	typedef struct packed {
		logic                 multi_best;
		logic                 no_second;
		logic [LOG_IDX_W-1:0] second_idx;
	} mate_s1_t;

	function automatic logic [LOG_IDX_W-1:0] cap_index(input logic [COUNT_W-1:0] count);
		logic [LOG_IDX_W-1:0] r;
		if (32'(count) > 32'(LOG_TABLE_DEPTH - 1)) begin
			r = LOG_IDX_W'(LOG_TABLE_DEPTH - 1);
		end else begin
			r = count[LOG_IDX_W-1:0];
		end
		return r;
	endfunction

	// rom: rounded 4.343*ln(idx), zero at index zero
	function automatic logic [LOG_VAL_W-1:0] log_value(input logic [LOG_IDX_W-1:0] idx);
		logic [LOG_VAL_W-1:0] v;
		v = '0;
		for (int k = 0; k < LOG_STEP_COUNT; k++) begin
			if (32'(idx) >= 32'(LOG_STEPS[k])) begin
				v = LOG_VAL_W'(k + 1);
			end
		end
		return v;
	endfunction

endpackage

### src/prmq_single_qual.sv
// single-end mapping quality of one mate from its registered hit flags
module prmq_single_qual (
	input  prmq_pkg::mate_s1_t            mate,
	output logic [prmq_pkg::QUAL_W-1:0]   qual
);
	import prmq_pkg::*;

	logic [LOG_VAL_W-1:0] lv;

	assign lv = log_value(mate.second_idx);

	always_comb begin
		if (mate.multi_best) begin
			qual = '0;
		end else if (mate.no_second) begin
			qual = Q_UNIQUE;
		end else if (QUAL_W'(lv) > Q_BASE) begin
			qual = '0;
		end else begin
			qual = Q_BASE - QUAL_W'(lv);
		end
	end

endmodule

### src/paired_read_mapping_quality.sv
// top level: paired-end mapping quality, three register stages
// an accepted word passes through stage 1, stage 2 and the output register before done rises with its result
// throughput: one read pair per cycle, busy is always low
// the receiver cannot stall, so nothing ever holds the pipeline
// reset clears the stage valid bits and done; the log table is constant logic
module paired_read_mapping_quality (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] best_hits_first,
	input  logic [15:0] second_hits_first,
	input  logic [15:0] best_hits_second,
	input  logic [15:0] second_hits_second,
	input  logic [9:0]  pair_best_score,
	input  logic [15:0] pair_best_count,
	input  logic [9:0]  pair_second_score,
	input  logic [15:0] pair_second_count,
	input  logic [9:0]  length_first,
	input  logic [9:0]  length_second,
	output logic        done,
	output logic [5:0]  quality_first,
	output logic [5:0]  quality_second
);
	import prmq_pkg::*;

	logic accept;

	// stage 1
	logic                 valid_s1;
	mate_s1_t             mate0_s1;
	mate_s1_t             mate1_s1;
	logic                 pair_one_s1;
	logic                 sub_zero_s1;
	logic [LOG_IDX_W-1:0] sub_idx_s1;
	logic signed [10:0]   diff_s1;
	logic [10:0]          len_sum_s1;

	// stage 2
	logic                 valid_s2;
	logic [QUAL_W-1:0]    q0_s2;
	logic [QUAL_W-1:0]    q1_s2;
	logic [QUAL_W-1:0]    pair_s2;

	logic [QUAL_W-1:0]    q0_c;
	logic [QUAL_W-1:0]    q1_c;
	logic [LOG_VAL_W-1:0] sub_log;
	logic [9:0]           half;
	logic signed [18:0]   hund;
	logic [11:0]          thr;
	logic signed [13:0]   five;
	logic signed [13:0]   raw;
	logic [QUAL_W-1:0]    pair_c;

	// stage 3
	logic [6:0]           sum;
	logic [6:0]           pp7;
	logic [QUAL_W-1:0]    q0_n;
	logic [QUAL_W-1:0]    q1_n;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mate0_s1.multi_best <= best_hits_first > 16'd1;
			mate0_s1.no_second  <= second_hits_first == '0;
			mate0_s1.second_idx <= cap_index(second_hits_first);
			mate1_s1.multi_best <= best_hits_second > 16'd1;
			mate1_s1.no_second  <= second_hits_second == '0;
			mate1_s1.second_idx <= cap_index(second_hits_second);
			pair_one_s1         <= pair_best_count == 16'd1;
			sub_zero_s1         <= pair_second_count == '0;
			sub_idx_s1          <= cap_index(pair_second_count);
			diff_s1             <= $signed({1'b0, pair_best_score})
			                     - $signed({1'b0, pair_second_score});
			len_sum_s1          <= 11'(length_first) + 11'(length_second);
		end
	end

	prmq_single_qual u_qual0 (
		.mate (mate0_s1),
		.qual (q0_c)
	);

	prmq_single_qual u_qual1 (
		.mate (mate1_s1),
		.qual (q1_c)
	);

	assign sub_log = log_value(sub_idx_s1);
	assign half    = len_sum_s1[10:1];
	assign hund    = 19'(diff_s1) * 19'sd100;
	assign thr     = 12'(half) * 12'd3;
	assign five    = 14'(diff_s1) * 14'sd5;
	assign raw     = five - $signed({9'b0, sub_log});

	always_comb begin
		if (!pair_one_s1) begin
			pair_c = '0;
		end else if (sub_zero_s1) begin
			pair_c = Q_PAIR_UNIQUE;
		end else if (hund > $signed({7'b0, thr})) begin
			pair_c = Q_PAIR_CLEAR;
		end else if (raw < 14'sd0) begin
			pair_c = '0;
		end else if (raw > $signed({8'b0, Q_PAIR_SAT})) begin
			pair_c = Q_PAIR_SAT;
		end else begin
			pair_c = raw[QUAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			q0_s2   <= q0_c;
			q1_s2   <= q1_c;
			pair_s2 <= pair_c;
		end
	end

	assign sum = 7'(q0_s2) + 7'(q1_s2);
	assign pp7 = 7'(pair_s2) + 7'(Q_PAIR_BONUS);

	always_comb begin
		if (q0_s2 != '0 && q1_s2 != '0) begin
			q0_n = (sum > 7'(Q_MAX)) ? Q_MAX : sum[QUAL_W-1:0];
			q1_n = q0_n;
		end else begin
			if (q0_s2 == '0) begin
				q0_n = (pp7 < 7'(q1_s2)) ? pp7[QUAL_W-1:0] : q1_s2;
			end else begin
				q0_n = q0_s2;
			end
			if (q1_s2 == '0) begin
				q1_n = (pp7 < 7'(q0_n)) ? pp7[QUAL_W-1:0] : q0_n;
			end else begin
				q1_n = q1_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			quality_first  <= q0_n;
			quality_second <= q1_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("accepted word did not produce a result after three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result without an accepted word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quality_first <= Q_MAX && quality_second <= Q_MAX))
		else $error("quality above cap");

	a_zero_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (quality_first == '0 || quality_second == '0))
			|-> (quality_first == '0 && quality_second == '0))
		else $error("only one mate has zero quality");
`endif

endmodule
